>>> hdl/assert_macros.svh
// Assertion macros for the RTL of the write-back cache.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> hdl/sawc_pkg.sv
// Package of the set-associative write-back cache: payload structs, request
// type codes and the fixed data width. Depends on nothing.
`default_nettype none
package sawc_pkg;
  localparam int DATA_BITS = 32;
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [19:0] address;
    logic signed [31:0] write_data;
  } sawc_req_t;

  typedef struct packed {
    logic signed [31:0] read_data;
    logic        hit;
    logic        wrote_back;
    logic [1:0]  way;
  } sawc_rsp_t;
endpackage
`default_nettype wire

>>> hdl/sawc_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Depends on nothing; it does not use sawc_pkg.
`default_nettype none
module sawc_ram #(
  parameter int AW = 10,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [DW-1:0] wdata,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> hdl/set_assoc_writeback_cache.sv
// Set-associative write-back cache, on a sequencer around three RAMs.
// Depends on sawc_pkg, sawc_ram and assert_macros.svh.
//
// One request is taken while busy is low; its result shows on out_* for one
// cycle with out_valid, and the receiver cannot stall. A hit passes through
// the states S_TAG, S_LOOK, S_RD and S_OUT. A clean miss adds one fill pass
// over the line, a dirty miss a write-back pass before it; both passes run
// through the single port of the line RAM and the backing RAM. After reset a
// clearing pass zeroes the backing RAM (with the tag/state RAM swept at its
// start) while busy stays high.
`default_nettype none
`include "assert_macros.svh"
module set_assoc_writeback_cache #(
  parameter int ADDR_BITS  = 20,
  parameter int SETS       = 128,
  parameter int WAYS       = 4,
  parameter int LINE_WORDS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire sawc_pkg::sawc_req_t in_req,
  output logic                     out_valid,
  output sawc_pkg::sawc_rsp_t      out_rsp
);
  import sawc_pkg::*;

  localparam int OB = $clog2(LINE_WORDS);
  localparam int SB = $clog2(SETS);
  localparam int WB = $clog2(WAYS);
  localparam int TB = ADDR_BITS - OB - SB;
  localparam int RB = (WAYS > 1) ? $clog2(WAYS) : 1;
  // One set row: per way valid, dirty, rank and tag.
  localparam int EW = 2 + RB + TB;
  localparam int RW = WAYS * EW;
  localparam int LB = SB + WB + OB;
  localparam logic [RB-1:0] OLDEST = RB'(WAYS - 1);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_TAG  = 4'd2;
  localparam logic [3:0] S_LOOK = 4'd3;
  localparam logic [3:0] S_WB   = 4'd4;
  localparam logic [3:0] S_FILL = 4'd5;
  localparam logic [3:0] S_RD   = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  logic [3:0] state_r, state_nxt;
  logic [ADDR_BITS:0] cnt_r, cnt_nxt;
  logic [OB:0] k_r, k_nxt;
  logic req_type_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [31:0] wdata_r;
  logic [RW-1:0] row_r;
  logic [WB-1:0] way_r, way_nxt;
  logic hit_r, hit_nxt, wb_r, wb_nxt;
  logic [RB-1:0] prev_r, prev_nxt;
  logic [TB-1:0] vtag_r, vtag_nxt;

  wire [OB-1:0] off = addr_r[OB-1:0];
  wire [SB-1:0] set = addr_r[OB+SB-1:OB];
  wire [TB-1:0] tag = addr_r[ADDR_BITS-1:OB+SB];

  // Tag/state RAM.
  logic ts_we;
  logic [SB-1:0] ts_addr;
  logic [RW-1:0] ts_wdata, ts_rdata;
  sawc_ram #(.AW(SB), .DW(RW)) u_tags (
    .clk(clk), .we(ts_we), .addr(ts_addr), .wdata(ts_wdata), .rdata(ts_rdata));

  // Line RAM.
  logic ln_we;
  logic [LB-1:0] ln_addr;
  logic [31:0] ln_wdata, ln_rdata;
  sawc_ram #(.AW(LB), .DW(DATA_BITS)) u_lines (
    .clk(clk), .we(ln_we), .addr(ln_addr), .wdata(ln_wdata), .rdata(ln_rdata));

  // Backing RAM.
  logic bk_we;
  logic [ADDR_BITS-1:0] bk_addr;
  logic [31:0] bk_wdata, bk_rdata;
  sawc_ram #(.AW(ADDR_BITS), .DW(DATA_BITS)) u_back (
    .clk(clk), .we(bk_we), .addr(bk_addr), .wdata(bk_wdata), .rdata(bk_rdata));

  function automatic logic [EW-1:0] ent(input logic [RW-1:0] r, input int i);
    return r[i*EW +: EW];
  endfunction

  // Lookup over the row just read.
  logic lk_hit, lk_inv;
  logic [WB-1:0] lk_hw, lk_iw, lk_ow;
  logic [RB-1:0] lk_best;
  always_comb begin
    logic [EW-1:0] e;
    lk_hit = 1'b0; lk_inv = 1'b0; lk_hw = '0; lk_iw = '0; lk_ow = '0;
    lk_best = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      e = ent(ts_rdata, i);
      if (e[EW-1] && e[TB-1:0] == tag) begin lk_hit = 1'b1; lk_hw = WB'(i); end
      if (!e[EW-1]) begin lk_inv = 1'b1; lk_iw = WB'(i); end
    end
    for (int i = 0; i < WAYS; i++) begin
      e = ent(ts_rdata, i);
      if (e[TB+RB-1:TB] > lk_best) begin lk_best = e[TB+RB-1:TB]; lk_ow = WB'(i); end
    end
  end

  // Updated row: served way most recent, fresh tag on a miss, dirty on write.
  logic [RW-1:0] row_upd;
  always_comb begin
    logic [EW-1:0] e;
    row_upd = row_r;
    for (int i = 0; i < WAYS; i++) begin
      e = ent(row_r, i);
      if (WB'(i) == way_r) begin
        e[EW-1] = 1'b1;
        if (!hit_r) begin e[TB-1:0] = tag; e[EW-2] = 1'b0; end
        if (req_type_r == REQ_WRITE) e[EW-2] = 1'b1;
        e[TB+RB-1:TB] = '0;
      end else if (e[EW-1] && e[TB+RB-1:TB] < prev_r && e[TB+RB-1:TB] < OLDEST) begin
        e[TB+RB-1:TB] = e[TB+RB-1:TB] + 1'b1;
      end
      row_upd[i*EW +: EW] = e;
    end
  end

  always_comb begin
    logic [EW-1:0] ve, he;
    state_nxt = state_r; cnt_nxt = cnt_r; k_nxt = k_r;
    way_nxt = way_r; hit_nxt = hit_r; wb_nxt = wb_r; prev_nxt = prev_r;
    vtag_nxt = vtag_r;
    ts_we = 1'b0; ts_addr = set; ts_wdata = row_upd;
    ln_we = 1'b0; ln_addr = {set, way_r, off}; ln_wdata = wdata_r;
    bk_we = 1'b0; bk_addr = {tag, set, off}; bk_wdata = ln_rdata;
    ve = ent(ts_rdata, int'(lk_inv ? lk_iw : lk_ow));
    he = ent(ts_rdata, int'(lk_hw));
    case (state_r)
      S_CLR: begin
        bk_we = 1'b1; bk_addr = cnt_r[ADDR_BITS-1:0]; bk_wdata = '0;
        ts_we = (cnt_r < (ADDR_BITS+1)'(SETS));
        ts_addr = cnt_r[SB-1:0]; ts_wdata = '0;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[ADDR_BITS-1:0] == '1) state_nxt = S_IDLE;
      end
      S_IDLE: if (start) state_nxt = S_TAG;
      S_TAG: state_nxt = S_LOOK;
      S_LOOK: begin
        hit_nxt = lk_hit; wb_nxt = 1'b0; k_nxt = '0;
        if (lk_hit) begin
          way_nxt = lk_hw; prev_nxt = he[TB+RB-1:TB];
          state_nxt = S_RD;
        end else begin
          way_nxt = lk_inv ? lk_iw : lk_ow; prev_nxt = OLDEST;
          vtag_nxt = ve[TB-1:0];
          if (ve[EW-1] && ve[EW-2]) begin wb_nxt = 1'b1; state_nxt = S_WB; end
          else state_nxt = S_FILL;
        end
      end
      S_WB: begin
        // Read line word k, write backing word k-1 from last cycle's read.
        ln_addr = {set, way_r, k_r[OB-1:0]};
        bk_addr = {vtag_r, set, k_r[OB-1:0] - 1'b1};
        bk_we = (k_r != '0);
        k_nxt = k_r + 1'b1;
        if (k_r == (OB+1)'(LINE_WORDS)) begin k_nxt = '0; state_nxt = S_FILL; end
      end
      S_FILL: begin
        bk_addr = {tag, set, k_r[OB-1:0]};
        ln_addr = {set, way_r, k_r[OB-1:0] - 1'b1};
        ln_wdata = bk_rdata; ln_we = (k_r != '0);
        k_nxt = k_r + 1'b1;
        if (k_r == (OB+1)'(LINE_WORDS)) state_nxt = S_RD;
      end
      S_RD: begin
        ln_addr = {set, way_r, off};
        ln_we = (req_type_r == REQ_WRITE);
        ts_we = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; cnt_r <= '0; k_r <= '0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; k_r <= k_nxt;
    end
    way_r <= way_nxt; hit_r <= hit_nxt; wb_r <= wb_nxt; prev_r <= prev_nxt;
    vtag_r <= vtag_nxt;
    if (state_r == S_LOOK) row_r <= ts_rdata;
    if (state_r == S_IDLE && start) begin
      req_type_r <= in_req.req_type;
      addr_r <= in_req.address[ADDR_BITS-1:0];
      wdata_r <= in_req.write_data;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  // The line RAM returns the old word during a write, so a write reports its own data.
  assign out_rsp.read_data = (req_type_r == REQ_WRITE) ? wdata_r : ln_rdata;
  assign out_rsp.hit = hit_r;
  assign out_rsp.wrote_back = wb_r;
  assign out_rsp.way = 2'(way_r);

  `ASSERT_IMPL(a_wb_miss, clk, rst_n, out_valid, !(hit_r && wb_r), "write-back on a hit")
  `ASSERT_NEXT(a_out_once, clk, rst_n, out_valid, !out_valid, "result repeated")
  `ASSERT_NEXT(a_look_from_tag, clk, rst_n, state_r == S_TAG, state_r == S_LOOK,
    "lookup skipped")
endmodule
`default_nettype wire

>>> verif/sawc_checker.sv
// Checker of the set-associative write-back cache: watches the request and
// result transfers, predicts each result and compares it. Depends on sawc_pkg.
module sawc_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  sawc_pkg::sawc_req_t in_req,
  input  logic                out_valid,
  input  sawc_pkg::sawc_rsp_t out_rsp,
  output int                  fail_count,
  output int                  pending_count,
  output int                  hit_seen,
  output int                  wb_seen
);
  import sawc_pkg::*;

  localparam int NSETS = 128;
  localparam int NWAYS = 4;
  localparam int NWORDS = 64;

  logic [6:0]  tags [NSETS][NWAYS];
  logic        valids [NSETS][NWAYS];
  logic        dirties [NSETS][NWAYS];
  logic [1:0]  ranks [NSETS][NWAYS];
  logic [31:0] lines [NSETS][NWAYS][NWORDS];
  logic [31:0] backing [int unsigned];
  sawc_rsp_t   expected_rsps [$];

  initial begin
    fail_count = 0;
    pending_count = 0;
    hit_seen = 0;
    wb_seen = 0;
    for (int s = 0; s < NSETS; s++) begin
      for (int w = 0; w < NWAYS; w++) begin
        valids[s][w] = 1'b0;
        dirties[s][w] = 1'b0;
        ranks[s][w] = 2'd0;
      end
    end
  end

  function automatic logic [31:0] backing_word(int unsigned a);
    if (backing.exists(a)) return backing[a];
    return 32'd0;
  endfunction

  // Runs one request against the cache image and returns its result.
  function automatic sawc_rsp_t serve_request(sawc_req_t req);
    sawc_rsp_t   rsp;
    logic [6:0]  tag;
    logic [6:0]  set;
    logic [5:0]  off;
    int          w;
    int          prev;
    int          best;
    bit          found;
    int unsigned base;
    tag = req.address[19:13];
    set = req.address[12:6];
    off = req.address[5:0];
    rsp = '0;
    w = 0;
    found = 0;
    for (int i = 0; i < NWAYS; i++) begin
      if (!found && valids[set][i] && tags[set][i] == tag) begin
        found = 1;
        w = i;
      end
    end
    rsp.hit = found;
    if (found) begin
      prev = ranks[set][w];
    end else begin
      for (int i = NWAYS - 1; i >= 0; i--) begin
        if (!valids[set][i]) begin
          w = i;
          found = 1;
        end
      end
      if (!found) begin
        best = 0;
        w = 0;
        for (int i = 0; i < NWAYS; i++) begin
          if (ranks[set][i] > best) begin
            best = ranks[set][i];
            w = i;
          end
        end
      end
      if (valids[set][w] && dirties[set][w]) begin
        base = {tags[set][w], set, 6'd0};
        for (int k = 0; k < NWORDS; k++) backing[base + k] = lines[set][w][k];
        rsp.wrote_back = 1'b1;
      end
      base = {req.address[19:6], 6'd0};
      for (int k = 0; k < NWORDS; k++) lines[set][w][k] = backing_word(base + k);
      tags[set][w] = tag;
      valids[set][w] = 1'b1;
      dirties[set][w] = 1'b0;
      prev = NWAYS - 1;
    end
    if (req.req_type == REQ_WRITE) begin
      lines[set][w][off] = req.write_data;
      dirties[set][w] = 1'b1;
    end
    rsp.read_data = lines[set][w][off];
    rsp.way = w[1:0];
    for (int i = 0; i < NWAYS; i++) begin
      if (i != w && valids[set][i] && ranks[set][i] < prev && ranks[set][i] < NWAYS - 1)
        ranks[set][i] = ranks[set][i] + 2'd1;
    end
    ranks[set][w] = 2'd0;
    return rsp;
  endfunction

  always @(posedge clk) begin
    sawc_rsp_t want;
    if (rst_n) begin
      if (start && !busy) expected_rsps.push_back(serve_request(in_req));
      if (out_valid) begin
        if (out_rsp.hit) hit_seen++;
        if (out_rsp.wrote_back) wb_seen++;
        if (expected_rsps.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transfer: %p", out_rsp);
        end else begin
          want = expected_rsps.pop_front();
          if (want.read_data !== out_rsp.read_data || want.hit !== out_rsp.hit ||
              want.wrote_back !== out_rsp.wrote_back || want.way !== out_rsp.way) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected data %h hit %b wb %b way %0d, got %h %b %b %0d",
                       want.read_data, want.hit, want.wrote_back, want.way,
                       out_rsp.read_data, out_rsp.hit, out_rsp.wrote_back, out_rsp.way);
          end
        end
      end
    end
    pending_count = expected_rsps.size();
  end
endmodule

>>> verif/tb_set_assoc_writeback_cache.sv
// Testbench top of the set-associative write-back cache: clock, reset and
// request stimulus. Depends on sawc_pkg, the cache RTL and sawc_checker.
module tb_set_assoc_writeback_cache;
  import sawc_pkg::*;

  localparam int RANDOM_REQS = 1830;
  localparam longint CYCLE_LIMIT = 8_000_000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  sawc_req_t in_req = '0;
  logic      out_valid;
  sawc_rsp_t out_rsp;
  int        fail_count;
  int        pending_count;
  int        hit_seen;
  int        wb_seen;
  longint    cycles = 0;
  int        req_count = 0;
  bit        quiet_sender = 0;

  set_assoc_writeback_cache i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_rsp(out_rsp)
  );

  sawc_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_rsp(out_rsp), .fail_count(fail_count),
    .pending_count(pending_count), .hit_seen(hit_seen), .wb_seen(wb_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Holds start high from a falling edge until the transfer is taken. busy
  // only moves at rising edges, so its value here holds for the next edge.
  task automatic send_request(logic kind, logic [19:0] addr, logic [31:0] data);
    bit taken;
    if (!quiet_sender) begin
      while ($urandom_range(99) < 31) begin
        start = 1'b0;
        in_req = {1'($urandom), 20'($urandom), 32'($urandom)};
        @(negedge clk);
      end
    end
    start = 1'b1;
    in_req.req_type = kind;
    in_req.address = addr;
    in_req.write_data = data;
    do begin
      taken = !busy;
      @(negedge clk);
    end while (!taken);
    start = 1'b0;
    req_count++;
  endtask

  // Mostly a few sets and a few tags each, so lines get reused and evicted.
  function automatic logic [19:0] pick_address();
    logic [19:0] a;
    a = 20'($urandom);
    if ($urandom_range(99) < 85) begin
      a[12:6] = 7'($urandom_range(3)) ^ (($urandom_range(9) == 0) ? 7'h7f : 7'h00);
      a[19:13] = 7'($urandom_range(6)) ^ (($urandom_range(7) == 0) ? 7'h7f : 7'h00);
    end
    return a;
  endfunction

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    send_request(REQ_READ, 20'h00000, 32'h0);
    send_request(REQ_WRITE, 20'hfffff, 32'h80000000);
    send_request(REQ_READ, 20'hfffff, 32'h0);
    send_request(REQ_WRITE, 20'h00000, 32'h7fffffff);
    send_request(REQ_WRITE, 20'h0003f, 32'hffffffff);
    send_request(REQ_READ, 20'h0003f, 32'h0);
    // Five tags in set 5: the fifth evicts the oldest dirty line.
    for (int t = 0; t < 5; t++)
      send_request(REQ_WRITE, {7'(t), 7'd5, 6'(t)}, 32'h1000 + t);
    send_request(REQ_READ, {7'd0, 7'd5, 6'd0}, 32'h0);
    send_request(REQ_READ, {7'd2, 7'd5, 6'd2}, 32'h0);
    send_request(REQ_READ, {7'd4, 7'd5, 6'd4}, 32'h0);
    send_request(REQ_WRITE, {7'd1, 7'd5, 6'd1}, 32'h5a5a5a5a);
    send_request(REQ_READ, {7'd3, 7'd5, 6'd3}, 32'h0);
    send_request(REQ_READ, {7'd1, 7'd5, 6'd1}, 32'h0);
    send_request(REQ_READ, 20'h7ffc0, 32'h0);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      quiet_sender = (n >= 600 && n < 900);
      send_request(1'($urandom), pick_address(), 32'($urandom));
    end

    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("%0d requests sent, %0d hits and %0d dirty write-backs seen",
             req_count, hit_seen, wb_seen);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
